FILE: design/gmix_pkg.sv
// Shared types and constants of the gain mixer with PCM output.
package gmix_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int GAIN_W    = 15;
	localparam int PCM_W     = 32;
	localparam int PROD_FRAC = 37;
	localparam int CFG_W     = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FORMAT   = 1'b1;

	localparam logic [1:0] FMT_S8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S24 = 2'd2;
	localparam logic [1:0] FMT_S32 = 2'd3;

	localparam logic [CFG_W-1:0] OUT_CHANNELS_RST = 2'd2;
	localparam logic [CFG_W-1:0] OUT_FORMAT_RST   = FMT_S16;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic sel_second;
		logic add;
		logic idx;
		logic num;
		logic load_out;
		logic out_last;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/gmix_ctrl.sv
// Sequencer for the gain mixer: steps each source beat through multiply, accumulate and emit.
module gmix_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  logic                 has_source,
	input  logic [1:0]           source_channels,
	input  logic                 last_source,
	input  logic                 oc_two,
	input  gmix_pkg::dp_status_t status,
	output gmix_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_ADD0,
		ST_MUL1,
		ST_ADD1,
		ST_NUM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   src_two_q;
	logic   ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= 1'b0;
			src_two_q <= 1'b0;
			ch_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						last_q    <= last_source;
						src_two_q <= source_channels[1];
						ch_q      <= 1'b0;
						if (has_source) begin
							state_q <= ST_MUL0;
						end else if (last_source) begin
							state_q <= ST_NUM;
						end
					end
				end
				ST_MUL0: state_q <= ST_ADD0;
				ST_ADD0: begin
					if (oc_two) begin
						// mono source reuses the held product for channel 1
						state_q <= src_two_q ? ST_MUL1 : ST_ADD1;
					end else if (last_q) begin
						state_q <= ST_NUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL1: state_q <= ST_ADD1;
				ST_ADD1: state_q <= last_q ? ST_NUM : ST_IDLE;
				ST_NUM:  state_q <= ST_OUT;
				ST_OUT: begin
					if (status.out_free) begin
						if (ch_q || !oc_two) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= 1'b1;
							state_q <= ST_NUM;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign src_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load_in    = (state_q == ST_IDLE) && src_valid;
		cmd.mul        = (state_q == ST_MUL0) || (state_q == ST_MUL1);
		cmd.sel_second = (state_q == ST_MUL1);
		cmd.add        = (state_q == ST_ADD0) || (state_q == ST_ADD1);
		cmd.idx        = (state_q == ST_ADD1) || (((state_q == ST_NUM) || (state_q == ST_OUT)) && ch_q);
		cmd.num        = (state_q == ST_NUM);
		cmd.load_out   = (state_q == ST_OUT) && status.out_free;
		cmd.out_last   = ch_q || !oc_two;
		cmd.clear      = cmd.load_out && cmd.out_last;
	end

endmodule

FILE: design/gmix_dp.sv
// Datapath of the gain mixer: gain multiply, saturating accumulators, PCM conversion, output register.
module gmix_dp #(
	parameter int SAMPLE_FRAC_BITS = 23,
	parameter int ACC_BITS         = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gmix_pkg::dp_cmd_t                   cmd,
	output gmix_pkg::dp_status_t                status,
	input  logic [1:0]                          out_format,
	input  logic signed [gmix_pkg::SAMPLE_W-1:0] sample_first,
	input  logic signed [gmix_pkg::SAMPLE_W-1:0] sample_second,
	input  logic [gmix_pkg::GAIN_W-1:0]         gain,
	output logic                                pcm_valid,
	input  logic                                pcm_stall,
	output logic signed [gmix_pkg::PCM_W-1:0]   pcm_sample,
	output logic                                channel_index,
	output logic                                frame_last
);

	localparam int PROD_W  = gmix_pkg::SAMPLE_W + gmix_pkg::GAIN_W;
	localparam int SHIFT   = gmix_pkg::PROD_FRAC - SAMPLE_FRAC_BITS;
	localparam int SUM_W   = ((ACC_BITS > PROD_W) ? ACC_BITS : PROD_W) + 1;
	localparam int V_W     = SAMPLE_FRAC_BITS + 2;
	localparam int CLIP_W  = (ACC_BITS > V_W) ? ACC_BITS : V_W;
	localparam int NUM_W   = SAMPLE_FRAC_BITS + gmix_pkg::PCM_W + 2;

	localparam logic signed [SUM_W-1:0] ACC_MAX =
		{{(SUM_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN =
		{{(SUM_W-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
	localparam logic signed [CLIP_W-1:0] ONE_C  = CLIP_W'(1) <<< SAMPLE_FRAC_BITS;
	localparam logic signed [NUM_W-1:0]  ONE_N  = NUM_W'(1) <<< SAMPLE_FRAC_BITS;
	localparam logic signed [NUM_W-1:0]  TRUNC_BIAS = (NUM_W'(1) <<< (SAMPLE_FRAC_BITS + 1)) - NUM_W'(1);

	logic signed [gmix_pkg::SAMPLE_W-1:0] first_q;
	logic signed [gmix_pkg::SAMPLE_W-1:0] second_q;
	logic [gmix_pkg::GAIN_W-1:0]          gain_q;
	logic signed [PROD_W-1:0]             prod_q;
	logic signed [ACC_BITS-1:0]           acc_q [2];
	logic signed [NUM_W-1:0]              num_q;
	logic                                 out_valid_q;
	logic signed [gmix_pkg::PCM_W-1:0]    pcm_q;
	logic                                 chan_q;
	logic                                 last_q;

	logic signed [gmix_pkg::SAMPLE_W-1:0] mul_a;
	logic signed [PROD_W-1:0]             prod_full;
	logic signed [PROD_W-1:0]             scaled;
	logic signed [SUM_W-1:0]              sum;
	logic signed [ACC_BITS-1:0]           sum_sat;
	logic signed [ACC_BITS-1:0]           acc_rd;
	logic signed [CLIP_W-1:0]             acc_x;
	logic signed [V_W-1:0]                v;
	logic signed [NUM_W-1:0]              vx;
	logic signed [NUM_W-1:0]              v_shl;
	logic signed [NUM_W-1:0]              num;
	logic signed [NUM_W-1:0]              num_adj;
	logic signed [NUM_W-1:0]              quot;

	assign status.out_free = !out_valid_q || !pcm_stall;

	// gain multiply: signed sample times non-negative gain
	assign mul_a     = cmd.sel_second ? second_q : first_q;
	assign prod_full = mul_a * $signed({1'b0, gain_q});

	// floor shift down to the accumulator scale, then saturating add
	assign scaled = prod_q >>> SHIFT;
	assign acc_rd = acc_q[cmd.idx];
	assign sum    = SUM_W'(acc_rd) + SUM_W'(scaled);

	always_comb begin
		if (sum > ACC_MAX) begin
			sum_sat = ACC_MAX[ACC_BITS-1:0];
		end else if (sum < ACC_MIN) begin
			sum_sat = ACC_MIN[ACC_BITS-1:0];
		end else begin
			sum_sat = sum[ACC_BITS-1:0];
		end
	end

	// clip to [-1, 1], then v*(2^n - 1) - 1 as shift and subtract
	assign acc_x = CLIP_W'(acc_rd);

	always_comb begin
		if (acc_x > ONE_C) begin
			v = ONE_C[V_W-1:0];
		end else if (acc_x < -ONE_C) begin
			v = V_W'(-ONE_C);
		end else begin
			v = acc_x[V_W-1:0];
		end
	end

	assign vx = NUM_W'(v);

	always_comb begin
		case (out_format)
			gmix_pkg::FMT_S8:  v_shl = vx <<< 8;
			gmix_pkg::FMT_S16: v_shl = vx <<< 16;
			gmix_pkg::FMT_S24: v_shl = vx <<< 24;
			gmix_pkg::FMT_S32: v_shl = vx <<< 32;
			default:           v_shl = vx <<< 16;
		endcase
	end

	assign num = v_shl - vx - ONE_N;

	// divide by 2^(F+1) truncating toward zero
	assign num_adj = num_q[NUM_W-1] ? (num_q + TRUNC_BIAS) : num_q;
	assign quot    = num_adj >>> (SAMPLE_FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			first_q  <= sample_first;
			second_q <= sample_second;
			gain_q   <= gain;
		end
		if (cmd.mul) begin
			prod_q <= prod_full;
		end
		if (cmd.num) begin
			num_q <= num;
		end
		if (cmd.load_out) begin
			pcm_q  <= quot[gmix_pkg::PCM_W-1:0];
			chan_q <= cmd.idx;
			last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				acc_q[0] <= '0;
				acc_q[1] <= '0;
			end else if (cmd.add) begin
				acc_q[cmd.idx] <= sum_sat;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!pcm_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pcm_valid     = out_valid_q;
	assign pcm_sample    = pcm_q;
	assign channel_index = chan_q;
	assign frame_last    = last_q;

endmodule

FILE: design/gain_mixer_with_pcm_output.sv
// Top level of the gain mixer with PCM output: configuration registers and the two units.
//
// Each source beat carries one source's share of the current output frame: one or two
// signed Q1.23 samples and an unsigned Q1.14 gain. The block multiplies each sample by
// the gain, floors it to the accumulator scale and adds it into one or two saturating
// accumulators (a mono source feeds both output channels, a stereo source into a mono
// output uses its first channel only). A beat with last_source set closes the frame:
// each accumulator is clipped to [-1, 1], converted to signed PCM at the configured
// width (8/16/24/32 bit, sign-extended on pcm_sample), sent out as one beat per output
// channel, and both accumulators are cleared. Items are handled one at a time by a
// sequencer driving a single shared multiplier and adder: each source beat is multiplied
// and added once per output channel (a mono source into stereo reuses its product), and
// closing a frame converts and emits each output channel in turn; no new source beat
// is taken until that is done. The single output register sets the pace of emission
// when the sink stalls. The next source beat is taken while the last PCM beat still waits
// in the output register. Write out_channels and out_format only while the block is idle.
module gain_mixer_with_pcm_output #(
	parameter int SAMPLE_FRAC_BITS = 23,
	parameter int ACC_BITS         = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [gmix_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gmix_pkg::CFG_W-1:0]           cfg_data,
	// source channel
	input  logic                                 src_valid,
	output logic                                 src_stall,
	input  logic                                 has_source,
	input  logic signed [gmix_pkg::SAMPLE_W-1:0] sample_first,
	input  logic signed [gmix_pkg::SAMPLE_W-1:0] sample_second,
	input  logic [1:0]                           source_channels,
	input  logic [gmix_pkg::GAIN_W-1:0]          gain,
	input  logic                                 last_source,
	// PCM channel
	output logic                                 pcm_valid,
	input  logic                                 pcm_stall,
	output logic signed [gmix_pkg::PCM_W-1:0]    pcm_sample,
	output logic                                 channel_index,
	output logic                                 frame_last
);

	logic [gmix_pkg::CFG_W-1:0] out_channels_q;
	logic [gmix_pkg::CFG_W-1:0] out_format_q;
	gmix_pkg::dp_cmd_t          cmd;
	gmix_pkg::dp_status_t       status;

	// Hold the configuration; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_channels_q <= gmix_pkg::OUT_CHANNELS_RST;
			out_format_q   <= gmix_pkg::OUT_FORMAT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				gmix_pkg::REG_OUT_CHANNELS: out_channels_q <= cfg_data;
				gmix_pkg::REG_OUT_FORMAT:   out_format_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts of 2 and 3 mean stereo output, 0 and 1 mean mono.
	gmix_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.has_source      (has_source),
		.source_channels (source_channels),
		.last_source     (last_source),
		.oc_two          (out_channels_q[1]),
		.status          (status),
		.cmd             (cmd)
	);

	gmix_dp #(
		.SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS),
		.ACC_BITS         (ACC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.out_format    (out_format_q),
		.sample_first  (sample_first),
		.sample_second (sample_second),
		.gain          (gain),
		.pcm_valid     (pcm_valid),
		.pcm_stall     (pcm_stall),
		.pcm_sample    (pcm_sample),
		.channel_index (channel_index),
		.frame_last    (frame_last)
	);

endmodule

FILE: design/gmix_checker.sv
// Port-level checks of the gain mixer, bound to the top level.
module gmix_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_stall,
	input logic        has_source,
	input logic        pcm_valid,
	input logic        pcm_stall,
	input logic [31:0] pcm_sample,
	input logic        channel_index,
	input logic        frame_last
);

	// a stalled PCM beat holds
	a_pcm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && pcm_stall |=> pcm_valid && $stable(pcm_sample)
			&& $stable(channel_index) && $stable(frame_last))
		else $error("stalled PCM beat changed");

	// channel 1 always closes a frame
	a_ch1_last: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && channel_index |-> frame_last)
		else $error("channel 1 beat without frame_last");

	// a beat that does not close the frame is on channel 0
	a_ch0_then_ch1: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && !pcm_stall && !frame_last |-> !channel_index)
		else $error("non-final beat not on channel 0");

	// a source beat keeps the block busy in the next cycle
	a_busy_after_source: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && has_source |=> src_stall)
		else $error("source beat accepted back to back");

endmodule

bind gain_mixer_with_pcm_output gmix_checker u_gmix_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.src_valid     (src_valid),
	.src_stall     (src_stall),
	.has_source    (has_source),
	.pcm_valid     (pcm_valid),
	.pcm_stall     (pcm_stall),
	.pcm_sample    (pcm_sample),
	.channel_index (channel_index),
	.frame_last    (frame_last)
);
